@@ sv/rasg_pkg.sv @@
// Shared types and constants for the radix all-to-all schedule generator.
// No dependencies; the output interface, controller, datapath and top import this package.
`default_nettype none

package rasg_pkg;

	localparam int RANK_W     = 10;
	localparam int CNT_W      = 11;
	localparam int PORT_W     = 4;
	localparam int STAGE_W    = 4;
	localparam int FIELD_W    = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_NODE_RANK  = 2'd0;
	localparam cfg_idx_t REG_NODE_COUNT = 2'd1;
	localparam cfg_idx_t REG_PORT_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} ctl_status_t;

	typedef struct packed {
		logic               entry_valid;
		logic [STAGE_W-1:0] stage_index;
		logic [FIELD_W-1:0] fraction_index;
		logic [FIELD_W-1:0] source_offset;
		logic [FIELD_W-1:0] dest_node;
		logic               dest_valid;
		logic [FIELD_W-1:0] src_node;
		logic               src_valid;
		logic               end_of_stage;
		logic               end_of_schedule;
	} out_item_t;

endpackage

`default_nettype wire

@@ sv/rasg_in_if.sv @@
// Input channel: one tick item carrying the restart flag.
// Depends on nothing.
`default_nettype none

interface rasg_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

@@ sv/rasg_out_if.sv @@
// Output channel: one schedule entry item.
// Depends on rasg_pkg for field widths.
`default_nettype none

interface rasg_out_if;
	import rasg_pkg::*;

	logic               valid;
	logic               ready;
	logic               entry_valid;
	logic [STAGE_W-1:0] stage_index;
	logic [FIELD_W-1:0] fraction_index;
	logic [FIELD_W-1:0] source_offset;
	logic [FIELD_W-1:0] dest_node;
	logic               dest_valid;
	logic [FIELD_W-1:0] src_node;
	logic               src_valid;
	logic               end_of_stage;
	logic               end_of_schedule;

	modport source (
		output valid, input ready,
		output entry_valid, output stage_index, output fraction_index, output source_offset,
		output dest_node, output dest_valid, output src_node, output src_valid,
		output end_of_stage, output end_of_schedule
	);
	modport sink (
		input valid, output ready,
		input entry_valid, input stage_index, input fraction_index, input source_offset,
		input dest_node, input dest_valid, input src_node, input src_valid,
		input end_of_stage, input end_of_schedule
	);
endinterface

`default_nettype wire

@@ sv/rasg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rasg_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

@@ sv/rasg_ctrl.sv @@
// Controller state machine: accept a tick, prepare, then load the entry.
// Depends on rasg_pkg for state, command and status types.
`default_nettype none

module rasg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rasg_pkg::ctl_status_t status,
	output rasg_pkg::ctl_cmd_t    cmd
);
	import rasg_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !status.div_busy;
				if (in_valid && !status.div_busy) begin
					cmd.accept = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				cmd.prep = 1'b1;
				state_d  = ST_CALC;
			end
			ST_CALC: begin
				// hold until the output register can take the entry
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

`default_nettype wire

@@ sv/rasg_dpath.sv @@
// Datapath: config registers, rank reduction, stage/index counters, source store,
// entry arithmetic and output register. Depends on rasg_pkg, rasg_out_if, rasg_ram.
`default_nettype none

module rasg_dpath #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_RADIX = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  rasg_pkg::cfg_idx_t                   cfg_index,
	input  logic [rasg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 restart,
	input  rasg_pkg::ctl_cmd_t                   cmd,
	output rasg_pkg::ctl_status_t                status,
	rasg_out_if.source                           entry
);
	import rasg_pkg::*;

	localparam int VW  = (MAX_NODES > 2048) ? CNT_W : $clog2(MAX_NODES);
	localparam int AW  = $clog2(MAX_NODES);
	localparam int RW  = $clog2(MAX_RADIX + 1);
	localparam int DGW = $clog2(MAX_RADIX);
	localparam int SW  = $clog2(MAX_NODES * MAX_RADIX);
	localparam int DCW = $clog2(RANK_W + 1);
	localparam int BW  = $clog2(RANK_W);

	// configuration
	logic [RANK_W-1:0] rank_q;
	logic [CNT_W-1:0]  count_q;
	logic [PORT_W-1:0] ports_q;
	logic [CNT_W-1:0]  n;
	logic [PORT_W:0]   r_raw;
	logic [RW-1:0]     r;
	logic              cfg_hit;
	logic              clear;

	// rank mod n, one bit per cycle
	logic [VW-1:0]  rem_q;
	logic [DCW-1:0] div_cnt_q;
	logic [BW-1:0]  div_idx;
	logic [VW:0]    div_try;
	logic [VW-1:0]  rem_next;

	// schedule state
	logic [STAGE_W-1:0] stage_q;
	logic [SW-1:0]      stride_q;
	logic [VW-1:0]      gp_q;
	logic [VW-1:0]      idx_q;
	logic               finished_q;
	logic               filled_q;
	logic [VW-1:0]      cto_q;
	logic [DGW-1:0]     dto_q;
	logic [VW-1:0]      shto_q;
	logic [VW-1:0]      cfr_q;
	logic [DGW-1:0]     dfr_q;
	logic [VW-1:0]      shfr_q;

	// prepared values
	logic [VW-1:0] to_q;
	logic [VW-1:0] from_q;
	logic [VW-1:0] frac_q;
	logic [VW:0]   to_sum;
	logic [VW:0]   frac_sum;
	logic [VW-1:0] to_v;
	logic [VW-1:0] from_v;
	logic [VW-1:0] frac_v;

	// entry step
	logic [VW-1:0]    ram_rdata;
	logic [VW-1:0]    s;
	logic [VW:0]      s_inc;
	logic [VW-1:0]    new_s;
	logic             has_to;
	logic             has_from;
	logic             last_idx;
	logic             ram_we;
	logic [VW:0]      cto_inc;
	logic             to_wrap;
	logic [DGW:0]     dto_inc;
	logic             dto_wrap;
	logic [SW:0]      shto_sum;
	logic [VW-1:0]    shto_next;
	logic [VW:0]      cfr_inc;
	logic             fr_wrap;
	logic [DGW:0]     dfr_inc;
	logic             dfr_wrap;
	logic [VW:0]      shfr_sum;
	logic [VW-1:0]    shfr_next;
	logic [SW+RW-1:0] prod;

	// output register
	out_item_t out_q;
	out_item_t out_d;
	logic      out_valid_q;

	// effective node count and radix
	always_comb begin
		if (count_q == '0) begin
			n = CNT_W'(1);
		end else if (32'(count_q) > MAX_NODES) begin
			n = CNT_W'(MAX_NODES);
		end else begin
			n = count_q;
		end
		r_raw = {1'b0, ports_q} + (PORT_W + 1)'(1);
		if (ports_q == '0) begin
			r = RW'(2);
		end else if (32'(r_raw) > MAX_RADIX) begin
			r = RW'(MAX_RADIX);
		end else begin
			r = RW'(r_raw);
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == REG_NODE_RANK || cfg_index == REG_NODE_COUNT ||
		cfg_index == REG_PORT_COUNT);
	assign clear = cfg_hit || (cmd.accept && restart);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q  <= '0;
			count_q <= CNT_W'(1);
			ports_q <= PORT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_RANK:  rank_q  <= cfg_data[RANK_W-1:0];
				REG_NODE_COUNT: count_q <= cfg_data[CNT_W-1:0];
				REG_PORT_COUNT: ports_q <= cfg_data[PORT_W-1:0];
				default: ;
			endcase
		end
	end

	// restoring reduction of the rank, MSB first
	assign div_idx  = BW'(div_cnt_q - DCW'(1));
	assign div_try  = {rem_q, rank_q[div_idx]};
	assign rem_next = (32'(div_try) >= 32'(n)) ? VW'(div_try - (VW + 1)'(n)) : VW'(div_try);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cfg_hit) begin
			rem_q     <= '0;
			div_cnt_q <= DCW'(RANK_W);
		end else if (div_cnt_q != '0) begin
			rem_q     <= rem_next;
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	// prepare destination, source and fraction
	always_comb begin
		to_sum   = (VW + 1)'(rem_q) + (VW + 1)'(shto_q);
		to_v     = (32'(to_sum) >= 32'(n)) ? VW'(to_sum - (VW + 1)'(n)) : VW'(to_sum);
		from_v   = (rem_q >= shfr_q) ? (rem_q - shfr_q) :
			VW'((VW + 1)'(rem_q) + (VW + 1)'(n) - (VW + 1)'(shfr_q));
		frac_sum = (VW + 1)'(idx_q) + (VW + 1)'(rem_q);
		frac_v   = (32'(frac_sum) >= 32'(n)) ? VW'(frac_sum - (VW + 1)'(n)) : VW'(frac_sum);
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			to_q   <= to_v;
			from_q <= from_v;
			frac_q <= frac_v;
		end
	end

	// source store: entries read as zero until the first stage has written them
	rasg_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_NODES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(idx_q)),
		.wdata(new_s),
		.raddr(AW'(idx_q)),
		.rdata(ram_rdata)
	);

	always_comb begin
		s        = filled_q ? ram_rdata : '0;
		has_to   = 32'(stride_q) < 32'(n);
		has_from = stage_q != '0;
		last_idx = (32'(idx_q) + 32'd1) >= 32'(n);
		s_inc    = (VW + 1)'(s) + (VW + 1)'(1);
		if (has_to) begin
			new_s = (s >= to_q) ? (s - to_q) :
				VW'((VW + 1)'(s) + (VW + 1)'(n) - (VW + 1)'(to_q));
		end else begin
			new_s = (32'(s_inc) >= 32'(n)) ? '0 : VW'(s_inc);
		end
		ram_we = cmd.load && !finished_q;

		cto_inc   = (VW + 1)'(cto_q) + (VW + 1)'(1);
		to_wrap   = 32'(cto_inc) == 32'(stride_q);
		dto_inc   = (DGW + 1)'(dto_q) + (DGW + 1)'(1);
		dto_wrap  = 32'(dto_inc) == 32'(r);
		shto_sum  = (SW + 1)'(shto_q) + (SW + 1)'(stride_q);
		shto_next = (32'(shto_sum) >= 32'(n)) ? VW'(shto_sum - (SW + 1)'(n)) : VW'(shto_sum);

		cfr_inc   = (VW + 1)'(cfr_q) + (VW + 1)'(1);
		fr_wrap   = 32'(cfr_inc) == 32'(gp_q);
		dfr_inc   = (DGW + 1)'(dfr_q) + (DGW + 1)'(1);
		dfr_wrap  = 32'(dfr_inc) == 32'(r);
		shfr_sum  = (VW + 1)'(shfr_q) + (VW + 1)'(gp_q);
		shfr_next = (32'(shfr_sum) >= 32'(n)) ? VW'(shfr_sum - (VW + 1)'(n)) : VW'(shfr_sum);

		prod = (SW + RW)'(stride_q) * (SW + RW)'(r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q    <= '0;
			stride_q   <= SW'(1);
			gp_q       <= VW'(1);
			idx_q      <= '0;
			finished_q <= 1'b0;
			filled_q   <= 1'b0;
			cto_q      <= '0;
			dto_q      <= '0;
			shto_q     <= '0;
			cfr_q      <= '0;
			dfr_q      <= '0;
			shfr_q     <= '0;
		end else if (clear) begin
			stage_q    <= '0;
			stride_q   <= SW'(1);
			gp_q       <= VW'(1);
			idx_q      <= '0;
			finished_q <= 1'b0;
			filled_q   <= 1'b0;
			cto_q      <= '0;
			dto_q      <= '0;
			shto_q     <= '0;
			cfr_q      <= '0;
			dfr_q      <= '0;
			shfr_q     <= '0;
		end else if (cmd.load && !finished_q) begin
			if (last_idx) begin
				idx_q    <= '0;
				stage_q  <= stage_q + STAGE_W'(1);
				filled_q <= 1'b1;
				cto_q    <= '0;
				dto_q    <= '0;
				shto_q   <= '0;
				cfr_q    <= '0;
				dfr_q    <= '0;
				shfr_q   <= '0;
				if (!has_to) begin
					finished_q <= 1'b1;
				end else begin
					gp_q     <= VW'(stride_q);
					stride_q <= prod[SW-1:0];
				end
			end else begin
				idx_q <= idx_q + VW'(1);
				if (to_wrap) begin
					cto_q <= '0;
					if (dto_wrap) begin
						dto_q  <= '0;
						shto_q <= '0;
					end else begin
						dto_q  <= DGW'(dto_inc);
						shto_q <= shto_next;
					end
				end else begin
					cto_q <= VW'(cto_inc);
				end
				if (fr_wrap) begin
					cfr_q <= '0;
					if (dfr_wrap) begin
						dfr_q  <= '0;
						shfr_q <= '0;
					end else begin
						dfr_q  <= DGW'(dfr_inc);
						shfr_q <= shfr_next;
					end
				end else begin
					cfr_q <= VW'(cfr_inc);
				end
			end
		end
	end

	// entry fields; all zero once the schedule has ended
	always_comb begin
		out_d = '0;
		if (!finished_q) begin
			out_d.entry_valid     = 1'b1;
			out_d.stage_index     = stage_q;
			out_d.fraction_index  = FIELD_W'(frac_q);
			out_d.source_offset   = FIELD_W'(s);
			out_d.dest_node       = has_to ? FIELD_W'(to_q) : '0;
			out_d.dest_valid      = has_to;
			out_d.src_node        = has_from ? FIELD_W'(from_q) : '0;
			out_d.src_valid       = has_from;
			out_d.end_of_stage    = last_idx;
			out_d.end_of_schedule = last_idx && !has_to;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (entry.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= out_d;
		end
	end

	assign status.div_busy = div_cnt_q != '0;
	assign status.out_free = !out_valid_q || entry.ready;

	assign entry.valid           = out_valid_q;
	assign entry.entry_valid     = out_q.entry_valid;
	assign entry.stage_index     = out_q.stage_index;
	assign entry.fraction_index  = out_q.fraction_index;
	assign entry.source_offset   = out_q.source_offset;
	assign entry.dest_node       = out_q.dest_node;
	assign entry.dest_valid      = out_q.dest_valid;
	assign entry.src_node        = out_q.src_node;
	assign entry.src_valid       = out_q.src_valid;
	assign entry.end_of_stage    = out_q.end_of_stage;
	assign entry.end_of_schedule = out_q.end_of_schedule;
endmodule

`default_nettype wire

@@ sv/radix_alltoall_schedule_generator_top.sv @@
// An entry is loaded into the output register once its tick has passed the accept and prepare
// steps and the register is free; a new tick is taken only after the last one is loaded
// (accept, prepare, store read-modify-write). A register write reduces the rank modulo the
// node count, one bit per cycle; no tick is accepted during that time. Reset is asynchronous,
// active low, and clears all control state; the source store needs no clearing pass, since
// its entries read as zero until the first stage of a schedule has written them.
`default_nettype none

module radix_alltoall_schedule_generator_top #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_RADIX = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  rasg_pkg::cfg_idx_t              cfg_index,
	input  logic [rasg_pkg::CFG_DATA_W-1:0] cfg_data,
	rasg_in_if.sink                         tick,
	rasg_out_if.source                      entry
);
	import rasg_pkg::*;

	ctl_cmd_t    cmd;
	ctl_status_t status;

	// Controller: walks each tick through accept, prepare and load, and holds
	// off new ticks while the rank reduction runs or a result is still being built.
	rasg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(tick.valid),
		.in_ready(tick.ready),
		.status  (status),
		.cmd     (cmd)
	);

	// Datapath: stage, stride and per-digit counters, the source store and the
	// output register. A restart tick clears the schedule before its entry is built;
	// a register write clears it without producing an entry.
	rasg_dpath #(
		.MAX_NODES(MAX_NODES),
		.MAX_RADIX(MAX_RADIX)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.restart  (tick.restart),
		.cmd      (cmd),
		.status   (status),
		.entry    (entry)
	);
endmodule

`default_nettype wire
